// File: rtl/core/idd_pkg.sv
package idd_pkg;

   // Field widths of the two channels.
   localparam int DATE_W  = 27;
   localparam int COUNT_W = 22;
   localparam int YEAR_W  = 14;
   localparam int ORD_W   = 23;

   // Register stages: eight in each lane, two in the merge stage.
   localparam int LANE_LATENCY  = 8;
   localparam int MERGE_LATENCY = 2;
   localparam int PIPE_LATENCY  = LANE_LATENCY + MERGE_LATENCY;

   // Reciprocals of 100, scaled so that the estimate is never more than one low.
   localparam logic [27:0] RECIP_DATE  = 28'd171798691;  // floor(2^34 / 100)
   localparam int          SHIFT_DATE  = 34;
   localparam logic [21:0] RECIP_MONTH = 22'd2684354;    // floor(2^28 / 100)
   localparam int          SHIFT_MONTH = 28;
   localparam logic [14:0] RECIP_YEAR  = 15'd20971;      // floor(2^21 / 100)
   localparam int          SHIFT_YEAR  = 21;

   localparam logic [6:0] MONTH_FIRST = 7'd1;
   localparam logic [6:0] MONTH_LAST  = 7'd12;
   localparam logic [6:0] MONTH_FEB   = 7'd2;

   typedef struct packed {
      logic [DATE_W-1:0] first_date;
      logic [DATE_W-1:0] second_date;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] day_count;
      logic               bad_date;
   } rsp_type;

   // What one lane hands to the merge stage.
   typedef struct packed {
      logic [ORD_W-1:0] ordinal;
      logic             bad;
   } lane_out_type;

   // Days before the start of each month in a common year.
   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage

// File: rtl/core/idd_lane.sv
module idd_lane (
   input  logic                           clock,
   input  logic [idd_pkg::DATE_W-1:0]     date,
   output idd_pkg::lane_out_type          result
);

   localparam int DW = idd_pkg::DATE_W;
   localparam int YW = idd_pkg::YEAR_W;
   localparam int OW = idd_pkg::ORD_W;

   // Stage 1: estimate of date / 100.
   logic [DW-1:0]          s1_date_ff, s1_date_in;
   logic [20:0]            s1_est_ff, s1_est_in;
   logic [DW+27:0]         s1_prod;
   // Stage 2: exact date / 100 and the day.
   logic [20:0]            s2_quot_ff, s2_quot_in;
   logic [6:0]             s2_day_ff, s2_day_in;
   logic [7:0]             s2_rem;
   // Stage 3: estimate of year.
   logic [20:0]            s3_quot_ff;
   logic [YW-1:0]          s3_est_ff, s3_est_in;
   logic [6:0]             s3_day_ff;
   logic [42:0]            s3_prod;
   // Stage 4: year and month.
   logic [YW-1:0]          s4_year_ff, s4_year_in;
   logic [6:0]             s4_month_ff, s4_month_in;
   logic [6:0]             s4_day_ff;
   logic [7:0]             s4_rem;
   // Stage 5: estimate of year / 100.
   logic [7:0]             s5_est_ff, s5_est_in;
   logic [YW-1:0]          s5_year_ff;
   logic [6:0]             s5_month_ff, s5_day_ff;
   logic [YW+14:0]         s5_prod;
   // Stage 6: century and year within century.
   logic [7:0]             s6_cent_ff, s6_cent_in;
   logic [6:0]             s6_yrem_ff, s6_yrem_in;
   logic [YW-1:0]          s6_year_ff;
   logic [6:0]             s6_month_ff, s6_day_ff;
   logic [7:0]             s6_rem;
   // Stage 7: days before the year and days within it.
   logic [OW-1:0]          s7_ydays_ff, s7_ydays_in;
   logic [9:0]             s7_mdays_ff, s7_mdays_in;
   logic                   s7_bad_ff, s7_bad_in;
   logic                   month_ok, leap, rem_nz;
   logic [11:0]            ceil4;
   logic [7:0]             ceil100;
   logic [5:0]             ceil400;
   // Stage 8: ordinal.
   idd_pkg::lane_out_type  s8_ff, s8_in;

   always_comb begin
      s1_date_in = date;
      s1_prod    = (DW+28)'(date) * (DW+28)'(idd_pkg::RECIP_DATE);
      s1_est_in  = s1_prod[idd_pkg::SHIFT_DATE +: 21];
   end

   // The estimate is exact or one low, so one compare and subtract fixes it.
   always_comb begin
      s2_rem = 8'(s1_date_ff - DW'(s1_est_ff) * DW'(100));
      if (s2_rem >= 8'd100) begin
         s2_quot_in = s1_est_ff + 21'd1;
         s2_day_in  = 7'(s2_rem - 8'd100);
      end else begin
         s2_quot_in = s1_est_ff;
         s2_day_in  = s2_rem[6:0];
      end
   end

   always_comb begin
      s3_prod   = 43'(s2_quot_ff) * 43'(idd_pkg::RECIP_MONTH);
      s3_est_in = s3_prod[idd_pkg::SHIFT_MONTH +: YW];
   end

   always_comb begin
      s4_rem = 8'(s3_quot_ff - 21'(s3_est_ff) * 21'd100);
      if (s4_rem >= 8'd100) begin
         s4_year_in  = s3_est_ff + YW'(1);
         s4_month_in = 7'(s4_rem - 8'd100);
      end else begin
         s4_year_in  = s3_est_ff;
         s4_month_in = s4_rem[6:0];
      end
   end

   always_comb begin
      s5_prod   = (YW+15)'(s4_year_ff) * (YW+15)'(idd_pkg::RECIP_YEAR);
      s5_est_in = s5_prod[idd_pkg::SHIFT_YEAR +: 8];
   end

   always_comb begin
      s6_rem = 8'(s5_year_ff - YW'(s5_est_ff) * YW'(100));
      if (s6_rem >= 8'd100) begin
         s6_cent_in = s5_est_ff + 8'd1;
         s6_yrem_in = 7'(s6_rem - 8'd100);
      end else begin
         s6_cent_in = s5_est_ff;
         s6_yrem_in = s6_rem[6:0];
      end
   end

   // Year zero counts as a leap year, so the days before year y are
   // 365*y + ceil(y/4) - ceil(y/100) + ceil(y/400).
   always_comb begin
      rem_nz   = (s6_yrem_ff != 7'd0);
      ceil4    = s6_year_ff[YW-1:2] + 12'(s6_year_ff[1:0] != 2'd0);
      ceil100  = s6_cent_ff + 8'(rem_nz);
      ceil400  = s6_cent_ff[7:2] + 6'(rem_nz || (s6_cent_ff[1:0] != 2'd0));
      leap     = ((s6_year_ff[1:0] == 2'd0) && rem_nz)
               || (!rem_nz && (s6_cent_ff[1:0] == 2'd0));
      month_ok = (s6_month_ff >= idd_pkg::MONTH_FIRST)
               && (s6_month_ff <= idd_pkg::MONTH_LAST);
      s7_ydays_in = OW'(s6_year_ff) * OW'(365) + OW'(ceil4) + OW'(ceil400)
                  - OW'(ceil100);
      s7_mdays_in = 10'(s6_day_ff)
                  + (month_ok ? 10'(idd_pkg::days_before(s6_month_ff[3:0])) : 10'd0)
                  + 10'(month_ok && (s6_month_ff > idd_pkg::MONTH_FEB) && leap);
      s7_bad_in   = !month_ok || (s6_day_ff == 7'd0);
   end

   always_comb begin
      s8_in.ordinal = s7_ydays_ff + OW'(s7_mdays_ff);
      s8_in.bad     = s7_bad_ff;
   end

   always_ff @(posedge clock) begin
      s1_date_ff  <= s1_date_in;
      s1_est_ff   <= s1_est_in;
      s2_quot_ff  <= s2_quot_in;
      s2_day_ff   <= s2_day_in;
      s3_quot_ff  <= s2_quot_ff;
      s3_est_ff   <= s3_est_in;
      s3_day_ff   <= s2_day_ff;
      s4_year_ff  <= s4_year_in;
      s4_month_ff <= s4_month_in;
      s4_day_ff   <= s3_day_ff;
      s5_est_ff   <= s5_est_in;
      s5_year_ff  <= s4_year_ff;
      s5_month_ff <= s4_month_ff;
      s5_day_ff   <= s4_day_ff;
      s6_cent_ff  <= s6_cent_in;
      s6_yrem_ff  <= s6_yrem_in;
      s6_year_ff  <= s5_year_ff;
      s6_month_ff <= s5_month_ff;
      s6_day_ff   <= s5_day_ff;
      s7_ydays_ff <= s7_ydays_in;
      s7_mdays_ff <= s7_mdays_in;
      s7_bad_ff   <= s7_bad_in;
      s8_ff       <= s8_in;
   end

   assign result = s8_ff;

endmodule

// File: rtl/core/idd_merge.sv
module idd_merge (
   input  logic                   clock,
   input  idd_pkg::lane_out_type  lane_a,
   input  idd_pkg::lane_out_type  lane_b,
   output idd_pkg::rsp_type       rsp
);

   localparam int OW = idd_pkg::ORD_W;
   localparam int CW = idd_pkg::COUNT_W;

   logic [OW-1:0]     diff_ff, diff_in;
   logic              bad_ff, bad_in;
   idd_pkg::rsp_type  rsp_ff, rsp_in;

   always_comb begin
      if (lane_a.ordinal > lane_b.ordinal) begin
         diff_in = lane_a.ordinal - lane_b.ordinal;
      end else begin
         diff_in = lane_b.ordinal - lane_a.ordinal;
      end
      bad_in = lane_a.bad || lane_b.bad;
   end

   // Inclusive count saturates at the largest value the field can hold.
   always_comb begin
      if (diff_ff >= OW'({CW{1'b1}})) begin
         rsp_in.day_count = {CW{1'b1}};
      end else begin
         rsp_in.day_count = CW'(diff_ff + OW'(1));
      end
      rsp_in.bad_date = bad_ff;
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      bad_ff  <= bad_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp = rsp_ff;

endmodule

// File: rtl/core/inclusive_date_difference_core.sv
// Channel    Ports                          Transfer
// --------   ----------------------------   -----------------------------------
// request    start, busy, req_data          edge with start high and busy low
// response   rsp_strobe, rsp_data           edge ending the single strobe cycle
//
// A new date pair can be taken in every cycle outside reset. Each result
// passes through eight register stages in each date lane (three
// reciprocal-of-100 divides, each a multiply stage and a correct stage, then
// two stages to build the day ordinal) and two in the merge stage.
// Reset is synchronous and clears only the valid pipeline; busy is high while
// reset is asserted. The receiver cannot stall, so nothing ever backs up.
module inclusive_date_difference_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  idd_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output idd_pkg::rsp_type  rsp_data
);

   localparam int LAT = idd_pkg::PIPE_LATENCY;

   logic [LAT-1:0]         vld_ff, vld_in;
   logic                   accept;
   idd_pkg::lane_out_type  lane_a_out, lane_b_out;

   // Nothing in the datapath holds an item back, so the only time a
   // transfer is refused is during reset.
   assign busy   = reset;
   assign accept = start && !busy;

   // One valid bit per stage travels alongside the data.
   always_comb begin
      vld_in = {vld_ff[LAT-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Each lane turns one packed date into a day ordinal and a bad-date flag.
   idd_lane u_lane_a (
      .clock  (clock),
      .date   (req_data.first_date),
      .result (lane_a_out)
   );

   idd_lane u_lane_b (
      .clock  (clock),
      .date   (req_data.second_date),
      .result (lane_b_out)
   );

   // The merge stage takes the absolute difference, adds one for the
   // inclusive count, saturates, and combines the two flags.
   idd_merge u_merge (
      .clock  (clock),
      .lane_a (lane_a_out),
      .lane_b (lane_b_out),
      .rsp    (rsp_data)
   );

   assign rsp_strobe = vld_ff[LAT-1];

endmodule

// File: rtl/core/idd_checker.sv
module idd_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  idd_pkg::req_type  req_data,
   input  logic              rsp_strobe,
   input  idd_pkg::rsp_type  rsp_data
);

   localparam int LAT = idd_pkg::PIPE_LATENCY;

   // Every request transfer yields a response a fixed time later.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_strobe)
      else $error("response missing after request transfer");

   // No response appears without a request transfer behind it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("response without a matching request");

   // The inclusive count is never zero.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.day_count != '0))
      else $error("day count of zero");

   // Identical dates always count as one day.
   a_same_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_data.first_date == req_data.second_date, LAT))
      |-> (rsp_data.day_count == idd_pkg::COUNT_W'(1)))
      else $error("equal dates did not give a count of one");

endmodule

bind inclusive_date_difference_core idd_checker u_idd_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// File: verif/inclusive_date_difference_core_tb.sv
`timescale 1ns / 100ps

module inclusive_date_difference_core_tb;

   localparam int DATE_W       = idd_pkg::DATE_W;
   localparam int COUNT_W      = idd_pkg::COUNT_W;
   localparam int PIPE_LATENCY = idd_pkg::PIPE_LATENCY;

   // Largest value the 22-bit day count can hold; longer spans saturate here.
   localparam int unsigned SPAN_LIMIT = (1 << COUNT_W) - 1;
   // Largest value a 27-bit date field can carry.
   localparam logic [DATE_W-1:0] DATE_FIELD_MAX = '1;
   // Highest year whose December 31 still fits in a 27-bit date field.
   localparam int unsigned YEAR_TOP = 13421;
   localparam int unsigned RANDOM_PAIRS = 1350;

   // Days before each month and length of each month in a common year.
   localparam int unsigned MONTH_OFFSET [1:12] =
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
   localparam int unsigned MONTH_DAYS [1:12] =
      '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   // One predicted result, kept with the date pair that caused it so that a
   // mismatch report can show the stimulus.
   typedef struct {
      idd_pkg::req_type pair;
      idd_pkg::rsp_type span;
   } pending_span_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   idd_pkg::req_type req_data;
   logic             rsp_strobe;
   idd_pkg::rsp_type rsp_data;

   pending_span_type pending_spans[$];
   int unsigned      transfer_count;
   int unsigned      failure_count;
   bit               sender_idles;

   inclusive_date_difference_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Safety net: the slowest correct run stays well under twenty microseconds.
   initial begin
      #400_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Gregorian leap rule: every fourth year, except centuries not divisible
   // by 400. Year 0 is therefore a leap year.
   function automatic bit is_leap_year(input int unsigned year);
      return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
   endfunction

   // Maps a packed YYYYMMDD date to a running day number. A month outside
   // 1-12 contributes no days-before-month term, and a day of zero adds
   // nothing; both mark the date as bad. Days past the end of a month simply
   // run on into the following months.
   function automatic int unsigned day_ordinal(input logic [DATE_W-1:0] date_value,
                                               output bit bad);
      int unsigned value;
      int unsigned year;
      int unsigned month;
      int unsigned day;
      int unsigned ordinal;
      value   = 32'(date_value);
      year    = value / 10000;
      month   = (value / 100) % 100;
      day     = value % 100;
      ordinal = 365 * year + (year + 3) / 4 - (year + 99) / 100 + (year + 399) / 400;
      bad     = 1'b0;
      if (month >= 1 && month <= 12) begin
         ordinal += MONTH_OFFSET[month];
         if (month > 2 && is_leap_year(year)) begin
            ordinal += 1;
         end
      end else begin
         bad = 1'b1;
      end
      if (day == 0) begin
         bad = 1'b1;
      end
      return ordinal + day;
   endfunction

   // Inclusive day count between the two dates of one request, saturated to
   // the width of the count field.
   function automatic idd_pkg::rsp_type predict_span(input idd_pkg::req_type pair);
      idd_pkg::rsp_type span;
      int unsigned      first_day;
      int unsigned      second_day;
      int unsigned      count;
      bit               first_bad;
      bit               second_bad;
      first_day  = day_ordinal(pair.first_date, first_bad);
      second_day = day_ordinal(pair.second_date, second_bad);
      count = (first_day > second_day) ? first_day - second_day : second_day - first_day;
      count += 1;
      if (count > SPAN_LIMIT) begin
         count = SPAN_LIMIT;
      end
      span.day_count = count[COUNT_W-1:0];
      span.bad_date  = first_bad | second_bad;
      return span;
   endfunction

   // ------------------------------------------------------------------------
   // Monitor and checker
   // ------------------------------------------------------------------------

   // Everything here samples at the rising edge, while the inputs driven at
   // the falling edge are stable. A request transfer happens at an edge with
   // start high and busy low; a result transfer at an edge that ends a
   // strobe cycle. The result always arrives many cycles after its request,
   // so recording and checking in the same edge cannot interfere.
   always @(posedge clock) begin
      pending_span_type oldest;
      if (!reset && start && !busy) begin
         oldest.pair = req_data;
         oldest.span = predict_span(req_data);
         pending_spans.push_back(oldest);
         transfer_count++;
      end
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_spans.size() == 0) begin
            failure_count++;
            if (failure_count <= 10) begin
               $display("Unexpected result: day_count %0d bad_date %b",
                        rsp_data.day_count, rsp_data.bad_date);
            end
         end else begin
            oldest = pending_spans.pop_front();
            // When a date is malformed the count is left unspecified, so only
            // the flag is compared in that case.
            if (rsp_data.bad_date !== oldest.span.bad_date ||
                (!oldest.span.bad_date && rsp_data.day_count !== oldest.span.day_count)) begin
               failure_count++;
               if (failure_count <= 10) begin
                  $display("Mismatch for %0d / %0d: expected count %0d bad %b, got count %0d bad %b",
                           oldest.pair.first_date, oldest.pair.second_date,
                           oldest.span.day_count, oldest.span.bad_date,
                           rsp_data.day_count, rsp_data.bad_date);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Offers one date pair and returns at the falling edge after its transfer.
   // Called at a falling edge. Start is written once per time step: it is
   // lowered only when an idle gap is taken, and raised after that gap.
   task automatic send_date_pair(input logic [DATE_W-1:0] first_date,
                                 input logic [DATE_W-1:0] second_date);
      int unsigned target;
      if (sender_idles && $urandom_range(99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(5, 1)) @(negedge clock);
      end
      target = transfer_count + 1;
      start  <= 1'b1;
      req_data.first_date  <= first_date;
      req_data.second_date <= second_date;
      do @(negedge clock); while (transfer_count < target);
   endtask

   // Holds the request side quiet until every expected result has come back.
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_spans.size() != 0) @(negedge clock);
   endtask

   function automatic logic [DATE_W-1:0] pack_date(input int unsigned year,
                                                   input int unsigned month,
                                                   input int unsigned day);
      int unsigned value;
      value = year * 10000 + month * 100 + day;
      return value[DATE_W-1:0];
   endfunction

   // Mostly years of the four-digit range, with a few beyond it where the
   // count can saturate.
   function automatic int unsigned random_year();
      if ($urandom_range(99) < 5) begin
         return $urandom_range(YEAR_TOP, 10000);
      end
      return $urandom_range(9999, 0);
   endfunction

   function automatic logic [DATE_W-1:0] random_valid_date(input int unsigned year);
      int unsigned month;
      int unsigned last_day;
      month    = $urandom_range(12, 1);
      last_day = MONTH_DAYS[month];
      if (month == 2 && is_leap_year(year)) begin
         last_day = 29;
      end
      return pack_date(year, month, $urandom_range(last_day, 1));
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Smallest and largest field values, the longest four-digit span, and a
   // span long enough to saturate the count.
   task automatic test_range_extremes();
      send_date_pair('0, '0);
      send_date_pair(DATE_FIELD_MAX, DATE_FIELD_MAX);
      send_date_pair('0, DATE_FIELD_MAX);
      send_date_pair(pack_date(0, 1, 1), pack_date(9999, 12, 31));
      send_date_pair(pack_date(0, 1, 1), pack_date(YEAR_TOP, 12, 31));
      send_date_pair(pack_date(9999, 12, 31), pack_date(9999, 12, 31));
   endtask

   // Century, four-hundred-year and ordinary leap rules, year 0, and a span
   // whose later year alone decides the leap day.
   task automatic test_leap_rules();
      send_date_pair(pack_date(1900, 2, 28), pack_date(1900, 3, 1));
      send_date_pair(pack_date(2000, 2, 28), pack_date(2000, 3, 1));
      send_date_pair(pack_date(2024, 2, 28), pack_date(2024, 3, 1));
      send_date_pair(pack_date(2023, 2, 28), pack_date(2023, 3, 1));
      send_date_pair(pack_date(0, 2, 28), pack_date(0, 3, 1));
      send_date_pair(pack_date(2023, 12, 31), pack_date(2024, 3, 1));
   endtask

   // Month above twelve, month zero, day zero, and both fields at 99.
   task automatic test_bad_fields();
      send_date_pair(pack_date(2024, 13, 1), pack_date(2024, 1, 1));
      send_date_pair(pack_date(2024, 0, 15), pack_date(2024, 1, 1));
      send_date_pair(pack_date(2024, 1, 0), pack_date(2024, 1, 1));
      send_date_pair(pack_date(2024, 99, 99), '0);
   endtask

   // A day beyond the end of its month rolls into the next month unflagged.
   task automatic test_day_overflow();
      send_date_pair(pack_date(2024, 1, 40), pack_date(2024, 2, 9));
      send_date_pair(pack_date(2023, 2, 29), pack_date(2023, 3, 1));
   endtask

   // The result must not depend on which date comes first.
   task automatic test_date_order();
      send_date_pair(pack_date(2024, 3, 1), pack_date(1999, 12, 31));
      send_date_pair(pack_date(1999, 12, 31), pack_date(2024, 3, 1));
   endtask

   // Random pairs: mostly well-formed dates, many of them close together so
   // that small counts and year boundaries get exercised, plus overlong days,
   // malformed fields and raw field noise. A long middle stretch runs with
   // no sender gaps, and one pause lets the pipeline empty completely.
   task automatic test_random_pairs();
      logic [DATE_W-1:0] first_date;
      logic [DATE_W-1:0] second_date;
      int unsigned       year;
      int unsigned       kind;
      for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
         sender_idles = !(n >= 500 && n < 800);
         if (n == 900) begin
            wait_for_drain();
         end
         kind = $urandom_range(99);
         year = random_year();
         if (kind < 45) begin
            first_date  = random_valid_date(year);
            second_date = random_valid_date(random_year());
         end else if (kind < 75) begin
            first_date  = random_valid_date(year);
            second_date = random_valid_date((year < YEAR_TOP) ? year + $urandom_range(1) : year);
         end else if (kind < 85) begin
            first_date  = pack_date(year, $urandom_range(12, 1), $urandom_range(99, 29));
            second_date = random_valid_date(year);
         end else if (kind < 92) begin
            first_date  = random_valid_date(year);
            case ($urandom_range(2))
               0:       second_date = pack_date(year, 0, $urandom_range(99));
               1:       second_date = pack_date(year, $urandom_range(99, 13), $urandom_range(99));
               default: second_date = pack_date(year, $urandom_range(99), 0);
            endcase
            if ($urandom_range(1)) begin
               {first_date, second_date} = {second_date, first_date};
            end
         end else begin
            first_date  = DATE_W'($urandom_range(DATE_FIELD_MAX));
            second_date = DATE_W'($urandom_range(DATE_FIELD_MAX));
         end
         send_date_pair(first_date, second_date);
      end
      sender_idles = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      transfer_count = 0;
      failure_count  = 0;
      sender_idles   = 1'b1;

      // Synchronous reset, released at a falling edge.
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_range_extremes();
      test_leap_rules();
      test_bad_fields();
      test_day_overflow();
      test_date_order();
      wait_for_drain();
      test_random_pairs();

      // Let every outstanding result arrive, then keep watching for longer than
      // the pipeline depth so that a stray extra strobe would still be caught.
      wait_for_drain();
      repeat (PIPE_LATENCY + 4) @(negedge clock);

      if (pending_spans.size() != 0) begin
         failure_count++;
         $display("%0d expected results never arrived", pending_spans.size());
      end
      if (failure_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
